// File: sv/sti_pkg.sv
// shared types, character codes and helper functions for the string to integer parser
package sti_pkg;

	localparam int RADIX_BITS = 6;
	localparam int DIGIT_BITS = 6;

	typedef logic [RADIX_BITS-1:0] radix_t;
	typedef logic [DIGIT_BITS-1:0] digit_val_t;

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_START,
		PH_ZERO,
		PH_XPEND,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef enum logic {
		CFG_RADIX       = 1'b0,
		CFG_SIGNED_MODE = 1'b1
	} cfg_idx_t;

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7a;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] LETTER_BASE = 8'h0a;

	localparam radix_t BASE_AUTO = 6'd0;
	localparam radix_t BASE_OCT  = 6'd8;
	localparam radix_t BASE_DEC  = 6'd10;
	localparam radix_t BASE_HEX  = 6'd16;

	localparam radix_t RADIX_RESET       = BASE_DEC;
	localparam logic   SIGNED_MODE_RESET = 1'b1;

	typedef struct packed {
		phase_t phase;
		logic   negative;
		logic   overflowed;
		logic   any_digit;
		radix_t eff_base;
	} parse_ctl_t;

	typedef struct packed {
		logic       ok;
		digit_val_t val;
	} digit_t;

	localparam parse_ctl_t CTL_CLEAR = '{
		phase:      PH_SKIP,
		negative:   1'b0,
		overflowed: 1'b0,
		any_digit:  1'b0,
		eff_base:   BASE_AUTO
	};

	function automatic logic is_white(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
			c == CH_FF || c == CH_CR;
	endfunction

	function automatic digit_t digit_of(logic [7:0] c);
		digit_t d;
		d.ok  = 1'b0;
		d.val = '0;
		if (c >= CH_0 && c <= CH_9) begin
			d.ok  = 1'b1;
			d.val = DIGIT_BITS'(c - CH_0);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d.ok  = 1'b1;
			d.val = DIGIT_BITS'(c - CH_LA + LETTER_BASE);
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d.ok  = 1'b1;
			d.val = DIGIT_BITS'(c - CH_UA + LETTER_BASE);
		end
		return d;
	endfunction

endpackage

// File: sv/sti_if.sv
// valid/ready channel interfaces for the character stream and the result stream
interface sti_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       first;

	modport source (output valid, output ch, output first, input ready);
	modport sink (input valid, input ch, input first, output ready);
endinterface

interface sti_out_if #(
	parameter int WORD_BITS   = 32,
	parameter int OFFSET_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [WORD_BITS-1:0]   value;
	logic                   range_error;
	logic [OFFSET_BITS-1:0] end_offset;

	modport source (output valid, output value, output range_error, output end_offset,
		input ready);
	modport sink (input valid, input value, input range_error, input end_offset,
		output ready);
endinterface

// File: sv/sti_step.sv
// per-character parse step: phase walk, digit accumulate with overflow test, result build
module sti_step
	import sti_pkg::*;
#(
	parameter int WORD_BITS   = 32,
	parameter int OFFSET_BITS = 16
) (
	input  logic [7:0]             ch,
	input  logic                   first,
	input  radix_t                 radix,
	input  logic                   signed_mode,
	input  parse_ctl_t             ctl_q,
	input  logic [WORD_BITS-1:0]   accum_q,
	input  logic [OFFSET_BITS-1:0] position_q,
	output parse_ctl_t             ctl_d,
	output logic [WORD_BITS-1:0]   accum_d,
	output logic [OFFSET_BITS-1:0] position_d,
	output logic                   emit,
	output logic [WORD_BITS-1:0]   res_value,
	output logic                   res_range_error,
	output logic [OFFSET_BITS-1:0] res_end_offset
);

	localparam int PROD_BITS = WORD_BITS + RADIX_BITS;
	localparam logic [WORD_BITS-1:0] MIN_MAG = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};

	parse_ctl_t             ctl_cur;
	logic [WORD_BITS-1:0]   accum_cur;
	logic [OFFSET_BITS-1:0] position_cur;
	digit_t                 dig;

	phase_t      ph;
	logic        neg;
	logic        anyd;
	radix_t      eb;
	logic        add_dig;
	logic [1:0]  adv;
	logic        stop;

	logic [PROD_BITS-1:0]   prod;
	logic                   prod_ovf;
	logic [OFFSET_BITS:0]   pos_sum;
	logic                   ovf_res;

	// a first character restarts the parse from the cleared state
	assign ctl_cur      = first ? CTL_CLEAR : ctl_q;
	assign accum_cur    = first ? '0 : accum_q;
	assign position_cur = first ? '0 : position_q;
	assign dig          = digit_of(ch);

	// phase walk, falling through phases in one step as needed
	always_comb begin
		ph      = ctl_cur.phase;
		neg     = ctl_cur.negative;
		anyd    = ctl_cur.any_digit;
		eb      = ctl_cur.eff_base;
		add_dig = 1'b0;
		adv     = 2'd0;
		emit    = 1'b0;
		stop    = 1'b0;

		if (ph == PH_SKIP) begin
			if (is_white(ch)) begin
				adv  = 2'd1;
				stop = 1'b1;
			end else begin
				ph = PH_START;
				if (ch == CH_MINUS || ch == CH_PLUS) begin
					neg  = (ch == CH_MINUS);
					adv  = 2'd1;
					stop = 1'b1;
				end
			end
		end

		if (!stop && ph == PH_START) begin
			if (radix == BASE_AUTO) begin
				if (ch == CH_0) begin
					eb   = BASE_OCT;
					anyd = 1'b1;
					adv  = 2'd1;
					ph   = PH_ZERO;
					stop = 1'b1;
				end else begin
					eb = BASE_DEC;
				end
			end else begin
				eb = radix;
				if (radix == BASE_HEX && ch == CH_0) begin
					anyd = 1'b1;
					adv  = 2'd1;
					ph   = PH_ZERO;
					stop = 1'b1;
				end
			end
			if (!stop) begin
				ph = PH_DIGITS;
			end
		end

		if (!stop && ph == PH_ZERO) begin
			if (ch == CH_LX || ch == CH_UX) begin
				eb   = BASE_HEX;
				ph   = PH_XPEND;
				stop = 1'b1;
			end else begin
				ph = PH_DIGITS;
			end
		end

		// the x is only counted once a hex digit follows it
		if (!stop && ph == PH_XPEND) begin
			if (!dig.ok || dig.val >= DIGIT_BITS'(BASE_HEX)) begin
				emit = 1'b1;
				ph   = PH_DONE;
				stop = 1'b1;
			end else begin
				adv = 2'd1;
				ph  = PH_DIGITS;
			end
		end

		if (!stop && ph == PH_DIGITS) begin
			if (!dig.ok || dig.val >= DIGIT_BITS'(eb)) begin
				emit = 1'b1;
				ph   = PH_DONE;
			end else begin
				add_dig = 1'b1;
				anyd    = 1'b1;
				adv     = adv + 2'd1;
			end
		end
	end

	// accumulate, saturating position and result value
	always_comb begin
		prod     = PROD_BITS'(accum_cur) * PROD_BITS'(eb) + PROD_BITS'(dig.val);
		prod_ovf = |prod[PROD_BITS-1:WORD_BITS];

		ctl_d.phase      = ph;
		ctl_d.negative   = neg;
		ctl_d.any_digit  = anyd;
		ctl_d.eff_base   = eb;
		ctl_d.overflowed = ctl_cur.overflowed | (add_dig & prod_ovf);

		accum_d = add_dig ? prod[WORD_BITS-1:0] : accum_cur;

		pos_sum = {1'b0, position_cur} + (OFFSET_BITS+1)'(adv);
		position_d = pos_sum[OFFSET_BITS] ? '1 : pos_sum[OFFSET_BITS-1:0];

		ovf_res = ctl_cur.overflowed;
		if (!ctl_cur.overflowed && signed_mode) begin
			if (ctl_cur.negative) begin
				ovf_res = accum_cur[WORD_BITS-1] & (|accum_cur[WORD_BITS-2:0]);
			end else begin
				ovf_res = accum_cur[WORD_BITS-1];
			end
		end

		if (ovf_res) begin
			if (signed_mode) begin
				res_value = ctl_cur.negative ? MIN_MAG : MAX_POS;
			end else begin
				res_value = '1;
			end
		end else begin
			res_value = ctl_cur.negative ? ('0 - accum_cur) : accum_cur;
		end
		res_range_error = ovf_res;
		res_end_offset  = anyd ? position_cur : '0;
	end

endmodule

// File: sv/sti_out_reg.sv
// result register with valid/ready handshake toward the sink
module sti_out_reg
	import sti_pkg::*;
#(
	parameter int WORD_BITS   = 32,
	parameter int OFFSET_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [WORD_BITS-1:0]   ld_value,
	input  logic                   ld_range_error,
	input  logic [OFFSET_BITS-1:0] ld_end_offset,
	output logic                   slot_free,
	sti_out_if.source              results
);

	logic                   valid_q;
	logic [WORD_BITS-1:0]   value_q;
	logic                   range_error_q;
	logic [OFFSET_BITS-1:0] end_offset_q;

	assign slot_free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q       <= ld_value;
			range_error_q <= ld_range_error;
			end_offset_q  <= ld_end_offset;
		end
	end

	assign results.valid       = valid_q;
	assign results.value       = value_q;
	assign results.range_error = range_error_q;
	assign results.end_offset  = end_offset_q;

endmodule

// File: sv/string_to_integer_parser.sv
// top level: input register, parse state, one-step parse logic and result register
// flow: an accepted character is held in the input register; when it moves on, its result is
// loaded into the result register; the step is bounded by the base multiply and add
// throughput: one character per cycle, unless a result finds the result register full
// reset: parse state cleared to whitespace skipping, radix 10, signed mode on, no result held
module string_to_integer_parser
	import sti_pkg::*;
#(
	parameter int WORD_BITS   = 32,
	parameter int OFFSET_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sti_in_if.sink                chars,
	sti_out_if.source             results,
	input  logic                  cfg_we,
	input  logic                  cfg_idx,
	input  logic [RADIX_BITS-1:0] cfg_data
);

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       first_s1;

	radix_t radix_q;
	logic   signed_mode_q;

	parse_ctl_t             ctl_q;
	logic [WORD_BITS-1:0]   accum_q;
	logic [OFFSET_BITS-1:0] position_q;

	parse_ctl_t             ctl_d;
	logic [WORD_BITS-1:0]   accum_d;
	logic [OFFSET_BITS-1:0] position_d;
	logic                   emit;
	logic [WORD_BITS-1:0]   res_value;
	logic                   res_range_error;
	logic [OFFSET_BITS-1:0] res_end_offset;

	logic slot_free;
	logic s1_go;
	logic in_take;

	// the staged character moves on unless its result finds the output full
	assign s1_go        = valid_s1 && (!emit || slot_free);
	assign chars.ready  = !valid_s1 || s1_go;
	assign in_take      = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= RADIX_RESET;
			signed_mode_q <= SIGNED_MODE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_RADIX:       radix_q <= cfg_data;
				CFG_SIGNED_MODE: signed_mode_q <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			ch_s1    <= chars.ch;
			first_s1 <= chars.first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q      <= CTL_CLEAR;
			accum_q    <= '0;
			position_q <= '0;
		end else if (s1_go) begin
			ctl_q      <= ctl_d;
			accum_q    <= accum_d;
			position_q <= position_d;
		end
	end

	sti_step #(
		.WORD_BITS  (WORD_BITS),
		.OFFSET_BITS(OFFSET_BITS)
	) u_step (
		.ch             (ch_s1),
		.first          (first_s1),
		.radix          (radix_q),
		.signed_mode    (signed_mode_q),
		.ctl_q          (ctl_q),
		.accum_q        (accum_q),
		.position_q     (position_q),
		.ctl_d          (ctl_d),
		.accum_d        (accum_d),
		.position_d     (position_d),
		.emit           (emit),
		.res_value      (res_value),
		.res_range_error(res_range_error),
		.res_end_offset (res_end_offset)
	);

	sti_out_reg #(
		.WORD_BITS  (WORD_BITS),
		.OFFSET_BITS(OFFSET_BITS)
	) u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (s1_go && emit),
		.ld_value      (res_value),
		.ld_range_error(res_range_error),
		.ld_end_offset (res_end_offset),
		.slot_free     (slot_free),
		.results       (results)
	);

endmodule

// File: sv/sti_checker.sv
// port-level checks for the string to integer parser and their bind
module sti_checker #(
	parameter int WORD_BITS   = 32,
	parameter int OFFSET_BITS = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [WORD_BITS-1:0]   out_value,
	input logic                   out_range_error,
	input logic [OFFSET_BITS-1:0] out_end_offset
);

	localparam logic [WORD_BITS-1:0] MIN_MAG = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) &&
			$stable(out_range_error) && $stable(out_end_offset))
		else $error("result changed while stalled");

	// no number parsed means a plain zero result
	a_no_digits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_end_offset == '0 |-> out_value == '0 && !out_range_error)
		else $error("empty parse gave a nonzero result");

	// a range error always carries a saturated value
	a_saturate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_range_error |->
			out_value == '1 || out_value == MIN_MAG || out_value == MAX_POS)
		else $error("range error without saturated value");

	// a new result needs a character transaction before it
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without an input transaction");

endmodule

bind string_to_integer_parser sti_checker #(
	.WORD_BITS  (WORD_BITS),
	.OFFSET_BITS(OFFSET_BITS)
) u_sti_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (chars.valid),
	.in_ready       (chars.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.out_value      (results.value),
	.out_range_error(results.range_error),
	.out_end_offset (results.end_offset)
);
